### rtl/gcci_pkg.sv
`timescale 1ns / 1ps
package gcci_pkg;

  localparam int DIM_W   = 11;
  localparam int CELL_W  = 30;
  localparam int VTX_W   = 33;
  localparam int CD_W    = 10;
  localparam int DIVQ_W  = 32;
  localparam int LAYER_W = 21;
  localparam int MAX_DIM = 1024;
  localparam int DIV_ITERS = 8;
  localparam int CNT_W = 3;

  // configuration register indexes
  localparam logic REG_DIM_X = 1'b0;
  localparam logic REG_DIM_Y = 1'b1;

  typedef struct packed {
    logic [CD_W-1:0]   x;
    logic [CD_W-1:0]   y;
    logic [CELL_W-1:0] z;
  } cell_pos_t;

  typedef struct packed {
    logic [CD_W-1:0]   rem;
    logic [DIVQ_W-1:0] q;
  } div_st_t;

  // clamp a dimension into 2..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d < DIM_W'(2)) begin
      r = DIM_W'(2);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // four restoring division steps, one quotient bit each
  function automatic div_st_t div_step4(input div_st_t s, input logic [CD_W-1:0] d);
    div_st_t      r;
    logic [CD_W:0] t;
    r = s;
    for (int i = 0; i < 4; i++) begin
      t = {r.rem, r.q[DIVQ_W-1]};
      r.q = {r.q[DIVQ_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem = CD_W'(t - {1'b0, d});
        r.q[0] = 1'b1;
      end else begin
        r.rem = t[CD_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

### rtl/gcci_div.sv
`timescale 1ns / 1ps
module gcci_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gcci_pkg::CELL_W-1:0] dividend,
  input  logic [gcci_pkg::CD_W-1:0]   divisor,
  output logic                       in_ready,
  output logic                       res_valid,
  input  logic                       take,
  output logic [gcci_pkg::CELL_W-1:0] quot,
  output logic [gcci_pkg::CD_W-1:0]   rem
);
  import gcci_pkg::*;

  div_st_t          st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             act_r, fin_r;
  div_st_t          init;

  assign in_ready  = !act_r && (!fin_r || take);
  assign res_valid = fin_r;
  assign quot      = st_r.q[CELL_W-1:0];
  assign rem       = st_r.rem;

  // first step runs on the load, seven more follow
  always_comb begin
    init.rem = '0;
    init.q   = {{(DIVQ_W-CELL_W){1'b0}}, dividend};
    if (start && in_ready) begin
      st_nxt = div_step4(init, divisor);
    end else if (act_r) begin
      st_nxt = div_step4(st_r, divisor);
    end else begin
      st_nxt = st_r;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (!rst_n) begin
      act_r <= 1'b0;
      fin_r <= 1'b0;
      cnt_r <= '0;
    end else if (start && in_ready) begin
      act_r <= 1'b1;
      fin_r <= 1'b0;
      cnt_r <= CNT_W'(1);
    end else if (act_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_ITERS - 1)) begin
        act_r <= 1'b0;
        fin_r <= 1'b1;
      end
    end else if (take) begin
      fin_r <= 1'b0;
    end
  end

endmodule

### rtl/gcci_front.sv
`timescale 1ns / 1ps
module gcci_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [gcci_pkg::CELL_W-1:0] cell_number,
  input  logic [gcci_pkg::CD_W-1:0]   cx,
  input  logic [gcci_pkg::CD_W-1:0]   cy,
  output logic                        pos_valid,
  input  logic                        pos_ready,
  output gcci_pkg::cell_pos_t         pos
);
  import gcci_pkg::*;

  logic              d1_ready, d1_valid, d2_ready, d2_valid;
  logic [CELL_W-1:0] q1, q2;
  logic [CD_W-1:0]   r1, r2;
  logic [CD_W-1:0]   x_r;

  assign busy = !d1_ready;

  // cell / (dim_x-1): remainder is x
  gcci_div u_div_x (
    .clk, .rst_n, .start(start), .dividend(cell_number), .divisor(cx),
    .in_ready(d1_ready), .res_valid(d1_valid), .take(d2_ready),
    .quot(q1), .rem(r1)
  );

  // row / (dim_y-1): remainder is y, quotient is z
  gcci_div u_div_yz (
    .clk, .rst_n, .start(d1_valid), .dividend(q1), .divisor(cy),
    .in_ready(d2_ready), .res_valid(d2_valid), .take(pos_ready),
    .quot(q2), .rem(r2)
  );

  // carry x along with the second division
  always_ff @(posedge clk) begin
    if (d1_valid && d2_ready) begin
      x_r <= r1;
    end
  end

  assign pos_valid = d2_valid;
  assign pos.x = x_r;
  assign pos.y = r2;
  assign pos.z = q2;

endmodule

### rtl/gcci_queue.sv
`timescale 1ns / 1ps
module gcci_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gcci_pkg::cell_pos_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output gcci_pkg::cell_pos_t head
);
  import gcci_pkg::*;

  cell_pos_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### rtl/gcci_back.sv
`timescale 1ns / 1ps
module gcci_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pos_valid,
  output logic                         pos_pop,
  input  gcci_pkg::cell_pos_t          pos,
  input  logic [gcci_pkg::DIM_W-1:0]   dx,
  input  logic [gcci_pkg::LAYER_W-1:0] layer,
  output logic                         out_strobe,
  output logic [gcci_pkg::VTX_W-1:0]   out_vertex_index,
  output logic [2:0]                   out_corner,
  output logic                         out_last
);
  import gcci_pkg::*;

  logic                  p_v_r;
  logic [CD_W-1:0]       px_r;
  logic [LAYER_W-1:0]    ydx_r;
  logic [VTX_W-1:0]      zl_r;
  logic [CELL_W+LAYER_W-1:0] zl_full;
  logic                  e_act_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [VTX_W-1:0]      base_r;
  logic                  e_load, p_load;

  assign e_load  = p_v_r && (!e_act_r || cnt_r == 3'd7);
  assign p_load  = pos_valid && (!p_v_r || e_load);
  assign pos_pop = p_load;
  assign zl_full = pos.z * layer;

  // product stage
  always_ff @(posedge clk) begin
    if (p_load) begin
      px_r  <= pos.x;
      ydx_r <= LAYER_W'(pos.y * dx);
      zl_r  <= zl_full[VTX_W-1:0];
    end
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (p_load) begin
      p_v_r <= 1'b1;
    end else if (e_load) begin
      p_v_r <= 1'b0;
    end
  end

  // corner emitter: base index, then walk the eight corners
  always_ff @(posedge clk) begin
    if (e_load) begin
      base_r <= VTX_W'(px_r) + VTX_W'(ydx_r) + zl_r;
    end
    if (!rst_n) begin
      e_act_r <= 1'b0;
      cnt_r   <= '0;
    end else if (e_load) begin
      e_act_r <= 1'b1;
      cnt_r   <= '0;
    end else if (e_act_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == 3'd7) begin
        e_act_r <= 1'b0;
      end
    end
  end

  assign out_strobe       = e_act_r;
  assign out_corner       = cnt_r;
  assign out_last         = e_act_r && (cnt_r == 3'd7);
  assign out_vertex_index = base_r + VTX_W'(cnt_r[0])
                          + (cnt_r[1] ? VTX_W'(dx) : '0)
                          + (cnt_r[2] ? VTX_W'(layer) : '0);

  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    e_act_r && cnt_r != 3'd7 |=> e_act_r && cnt_r == $past(cnt_r) + 3'd1)
    else $error("corner walk broke off");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    e_load |=> out_strobe && out_corner == 3'd0)
    else $error("cell did not start at corner 0");
  a_pstage: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r && !e_load |=> p_v_r && $stable(zl_r))
    else $error("product stage lost a cell");

endmodule

### rtl/grid_cell_corner_indices_core.sv
`timescale 1ns / 1ps
// Once the first corner of a cell appears, its corners follow at one corner per cycle.
// Cell rate is bounded by the two chained 4-bit-per-cycle dividers and by the
// eight-corner output walk.
// Reset: synchronous active-low; dims return to 1024, all queues and units empty.
// The receiver cannot stall; each corner word shows for exactly one cycle.
module grid_cell_corner_indices_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [gcci_pkg::CELL_W-1:0]  in_cell_number,
  output logic                         out_strobe,
  output logic [gcci_pkg::VTX_W-1:0]   out_vertex_index,
  output logic [2:0]                   out_corner,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [gcci_pkg::DIM_W-1:0]   cfg_data
);
  import gcci_pkg::*;

  logic [DIM_W-1:0]   dim_x_r, dim_y_r, dx, dy;
  logic [CD_W-1:0]    cx, cy;
  logic [LAYER_W-1:0] layer_r;
  logic [2*DIM_W-1:0] layer_full;
  logic               f_valid, q_full, q_ne, pop;
  cell_pos_t          f_pos, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_x_r <= DIM_W'(1024);
      dim_y_r <= DIM_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM_X: dim_x_r <= cfg_data;
        REG_DIM_Y: dim_y_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign dx = clamp_dim(dim_x_r);
  assign dy = clamp_dim(dim_y_r);
  assign cx = CD_W'(dx - DIM_W'(1));
  assign cy = CD_W'(dy - DIM_W'(1));
  assign layer_full = dx * dy;

  // layer size, used only well after the dividers
  always_ff @(posedge clk) begin
    layer_r <= layer_full[LAYER_W-1:0];
  end

  gcci_front u_front (
    .clk, .rst_n, .start, .busy, .cell_number(in_cell_number),
    .cx, .cy, .pos_valid(f_valid), .pos_ready(!q_full), .pos(f_pos)
  );

  gcci_queue u_queue (
    .clk, .rst_n, .push(f_valid), .push_data(f_pos), .full(q_full),
    .pop, .not_empty(q_ne), .head(q_head)
  );

  gcci_back u_back (
    .clk, .rst_n, .pos_valid(q_ne), .pos_pop(pop), .pos(q_head),
    .dx, .layer(layer_r), .out_strobe, .out_vertex_index, .out_corner, .out_last
  );

endmodule

### sim/grid_cell_corner_indices_core_test.sv
`timescale 1ns / 1ps
module grid_cell_corner_indices_core_test;
  import gcci_pkg::*;

  typedef struct {
    logic [VTX_W-1:0] vertex_index;
    logic [2:0]       corner;
    logic             last;
  } corner_word_t;

  // Predicts the corner vertex words of each cell and checks them in order
  class corner_scoreboard;
    corner_word_t pending[$];
    logic [DIM_W-1:0] dim_x_reg = DIM_W'(1024);
    logic [DIM_W-1:0] dim_y_reg = DIM_W'(1024);
    int mismatches = 0;

    function logic [63:0] eff_dim(logic [DIM_W-1:0] d);
      if (d < 2) return 64'd2;
      if (d > MAX_DIM) return 64'(MAX_DIM);
      return 64'(d);
    endfunction

    function void set_dim(logic idx, logic [DIM_W-1:0] v);
      if (idx == REG_DIM_X) dim_x_reg = v;
      else dim_y_reg = v;
    endfunction

    function void note_cell(logic [CELL_W-1:0] cell_num);
      logic [63:0] dx, dy, px, py, pz, v;
      corner_word_t w;
      dx = eff_dim(dim_x_reg);
      dy = eff_dim(dim_y_reg);
      px = 64'(cell_num) % (dx - 1);
      py = (64'(cell_num) / (dx - 1)) % (dy - 1);
      pz = 64'(cell_num) / ((dx - 1) * (dy - 1));
      for (int c = 0; c < 8; c++) begin
        v = (px + c[0]) + (py + c[1]) * dx + (pz + c[2]) * dx * dy;
        w.vertex_index = v[VTX_W-1:0];
        w.corner = c[2:0];
        w.last = (c == 7);
        pending.push_back(w);
      end
    endfunction

    function void check_word(logic [VTX_W-1:0] vi, logic [2:0] cn, logic lst);
      corner_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: vertex %0d corner %0d", vi, cn);
        return;
      end
      e = pending.pop_front();
      if (e.vertex_index !== vi || e.corner !== cn || e.last !== lst) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp vertex %0d corner %0d last %0b, got %0d %0d %0b",
                   e.vertex_index, e.corner, e.last, vi, cn, lst);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CELL_W-1:0] in_cell_number = '0;
  logic out_strobe;
  logic [VTX_W-1:0] out_vertex_index;
  logic [2:0] out_corner;
  logic out_last;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [DIM_W-1:0] cfg_data = '0;

  corner_scoreboard sb = new();
  int idle_pct = 0;

  grid_cell_corner_indices_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cell_number(in_cell_number), .out_strobe(out_strobe),
    .out_vertex_index(out_vertex_index), .out_corner(out_corner),
    .out_last(out_last), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Check each strobed word at the edge that accepts it
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_word(out_vertex_index, out_corner, out_last);
  end

  // Send one cell word, with random idle cycles ahead of it; start stays
  // high after the accept until the next send or write drives it
  task automatic send_cell(logic [CELL_W-1:0] cell_num);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cell_number <= cell_num;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cell(cell_num);
  endtask

  // Drain, then write one register while idle
  task automatic write_dim(logic idx, logic [DIM_W-1:0] v);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_dim(idx, v);
  endtask

  function automatic logic [CELL_W-1:0] rand_cell();
    case ($urandom_range(3))
      0: return CELL_W'($urandom_range(0, 4000));
      1: return CELL_W'($urandom);
      2: return {CELL_W{1'b1}} - CELL_W'($urandom_range(0, 3));
      default: return CELL_W'($urandom_range(0, 2000000));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(4))
      0: return DIM_W'($urandom_range(0, 1));
      1: return DIM_W'($urandom_range(1025, 2047));
      2: return DIM_W'($urandom_range(2, 6));
      default: return DIM_W'($urandom_range(2, 1024));
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset dims, field extremes, clamping, cells past the z extent
    send_cell('0);
    send_cell({CELL_W{1'b1}});
    send_cell(CELL_W'(1022));
    send_cell(CELL_W'(1023));
    send_cell(CELL_W'(1023 * 1023));
    write_dim(REG_DIM_X, DIM_W'(0));
    write_dim(REG_DIM_Y, DIM_W'(1));
    send_cell('0);
    send_cell(CELL_W'(5));
    send_cell({CELL_W{1'b1}});
    write_dim(REG_DIM_X, DIM_W'(2047));
    write_dim(REG_DIM_Y, DIM_W'(1025));
    send_cell(CELL_W'(1023));
    send_cell({CELL_W{1'b1}});
    send_cell(CELL_W'(30'h2AAAAAAA));
    send_cell(CELL_W'(30'h15555555));
    write_dim(REG_DIM_X, DIM_W'(3));
    write_dim(REG_DIM_Y, DIM_W'(1024));
    send_cell(CELL_W'(2));
    send_cell(CELL_W'(2046));
    send_cell({CELL_W{1'b1}});

    // Random phases: sender idle 29%, then 58%, then none
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 29 : (ph < 8) ? 58 : 0;
      write_dim(REG_DIM_X, rand_dim());
      write_dim(REG_DIM_Y, rand_dim());
      for (int i = 0; i < 33; i++) send_cell(rand_cell());
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
